@@ design/tsbs_pkg.sv @@
// Shared constants, types and arithmetic helpers for the selective box smoother.
package tsbs_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int DimW      = 11;
  localparam int ThrW      = 8;
  localparam int ChanW     = 8;
  localparam int PixW      = 3 * ChanW;
  localparam int QDepth    = 4;
  localparam int QAddrW    = $clog2(QDepth);
  localparam int SlotN     = 4;

  // Configuration register indexes
  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgThresh = 2'd2;

  localparam logic [DimW-1:0] DimMin      = DimW'(2);
  localparam logic [DimW-1:0] WidthMax    = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax   = DimW'(MaxHeight);
  localparam logic [DimW-1:0] WidthReset  = DimW'(512);
  localparam logic [DimW-1:0] HeightReset = DimW'(512);
  localparam logic [ThrW-1:0] ThreshReset = ThrW'(30);

  // Pixel: red in the low byte, then green, then blue
  typedef logic [PixW-1:0] pix_t;

  // One classified pixel handed from the front to the back.
  // slots: bit 0 row above / previous column, bit 1 row above / last column,
  //        bit 2 last row / previous column,   bit 3 last row / last column
  typedef struct packed {
    pix_t              vc0;
    pix_t              pc0;
    pix_t              vc1;
    pix_t              pc1;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [SlotN-1:0]  slots;
  } job_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < DimMin) r = DimMin;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // floor(s/3) for s <= 765 through the reciprocal 683/2048
  function automatic logic [ChanW-1:0] div3(input logic [ChanW+1:0] s);
    logic [19:0] prod;
    prod = 20'(s) * 20'd683;
    return prod[18:11];
  endfunction

  function automatic pix_t mean3(input pix_t a, input pix_t b, input pix_t c);
    pix_t r;
    logic [ChanW+1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = (ChanW+2)'(a[k*ChanW +: ChanW]) + (ChanW+2)'(b[k*ChanW +: ChanW])
        + (ChanW+2)'(c[k*ChanW +: ChanW]);
      r[k*ChanW +: ChanW] = div3(s);
    end
    return r;
  endfunction

  function automatic pix_t choose(input pix_t sm, input pix_t orig,
                                 input logic [ThrW-1:0] thr);
    pix_t r;
    logic [ChanW-1:0] s;
    logic [ChanW-1:0] o;
    logic [ChanW-1:0] d;
    for (int k = 0; k < 3; k++) begin
      s = sm[k*ChanW +: ChanW];
      o = orig[k*ChanW +: ChanW];
      d = (s > o) ? s - o : o - s;
      r[k*ChanW +: ChanW] = (d > thr) ? s : o;
    end
    return r;
  endfunction

endpackage

@@ design/tsbs_front.sv @@
// Front end: pixel position tracking, line store and vertical means.
module tsbs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tsbs_pkg::pix_t              in_pix_i,
  input  logic [tsbs_pkg::DimW-1:0]   cfg_width_i,
  input  logic [tsbs_pkg::DimW-1:0]   cfg_height_i,
  output logic                        push_o,
  output tsbs_pkg::job_t              job_o,
  input  logic                        q_full_i
);
  import tsbs_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [DimW-1:0] act_w_q, act_h_q;
  logic [DimW-1:0] eff_w, eff_h;
  logic            first_pix, last_col, last_row, accept;

  logic            s1_valid_q;
  pix_t            s1_pix_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic            s1_top_q;
  logic [SlotN-1:0] s1_slots_q;
  logic [SlotN-1:0] slots;

  // upper row in the high half, lower row in the low half
  logic [2*PixW-1:0] line_mem [MaxWidth];
  logic [2*PixW-1:0] rd_q;
  pix_t mid, above;

  assign first_pix = (col_q == '0) && (row_q == '0);
  assign eff_w     = first_pix ? clamp_dim(cfg_width_i, WidthMax)   : act_w_q;
  assign eff_h     = first_pix ? clamp_dim(cfg_height_i, HeightMax) : act_h_q;
  assign last_col  = (DimW'(col_q) + DimW'(1)) == eff_w;
  assign last_row  = (DimW'(row_q) + DimW'(1)) == eff_h;

  assign push_o     = s1_valid_q && !q_full_i;
  assign in_ready_o = !s1_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic t0, t1, has_prev;
    t0       = (row_q != '0);
    t1       = t0 && last_row;
    has_prev = (col_q != '0);
    slots    = {t1 && last_col, t1 && has_prev, t0 && last_col, t0 && has_prev};
  end

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      act_w_q    <= WidthReset;
      act_h_q    <= HeightReset;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        act_w_q <= eff_w;
        act_h_q <= eff_h;
      end
      if (in_ready_o) s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= in_pix_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_top_q   <= (row_q > RowW'(1));
      s1_slots_q <= slots;
    end
  end

  // Line store: read on accept, write back the shifted pair when the item leaves
  always_ff @(posedge clk_i) begin
    if (push_o) line_mem[s1_col_q] <= {mid, s1_pix_q};
    if (accept) rd_q <= line_mem[col_q];
  end

  assign mid   = rd_q[PixW-1:0];
  assign above = s1_top_q ? rd_q[2*PixW-1:PixW] : s1_pix_q;

  always_comb begin
    job_o.vc0   = mean3(above, mid, s1_pix_q);
    job_o.pc0   = mid;
    job_o.vc1   = mean3(mid, s1_pix_q, mid);
    job_o.pc1   = s1_pix_q;
    job_o.col   = s1_col_q;
    job_o.row   = s1_row_q;
    job_o.slots = s1_slots_q;
  end

endmodule

@@ design/tsbs_queue.sv @@
// Short job queue between front and back.
module tsbs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tsbs_pkg::job_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tsbs_pkg::job_t  data_o
);
  import tsbs_pkg::*;

  job_t              entry_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAddrW:0]   count_q;
  logic              do_pop;

  assign full_o  = (count_q == (QAddrW+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QAddrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QAddrW'(1);
      if (push_i && !do_pop) count_q <= count_q + (QAddrW+1)'(1);
      else if (do_pop && !push_i) count_q <= count_q - (QAddrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ design/tsbs_back.sv @@
// Back end: horizontal means, threshold select and result register.
module tsbs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  tsbs_pkg::job_t              job_i,
  output logic                        pop_o,
  input  logic [tsbs_pkg::ThrW-1:0]   thr_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tsbs_pkg::pix_t              out_pix_o,
  output logic [tsbs_pkg::ColW-1:0]   out_col_o,
  output logic [tsbs_pkg::RowW-1:0]   out_row_o,
  output logic                        out_last_o
);
  import tsbs_pkg::*;

  localparam logic [1:0] SlotUpPrev   = 2'd0;
  localparam logic [1:0] SlotUpLast   = 2'd1;
  localparam logic [1:0] SlotBotPrev  = 2'd2;
  localparam logic [1:0] SlotBotLast  = 2'd3;

  // per track: two most recent vertical means and the last center pixel
  pix_t win_v0_q [2];
  pix_t win_v1_q [2];
  pix_t win_cp_q [2];

  logic [SlotN-1:0] done_q, pend, sel_mask;
  logic [1:0]       sel;
  logic             load_ok, emit, last_slot;

  logic             out_valid_q;
  pix_t             out_pix_q;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic             out_last_q;

  pix_t            vc, pc, wv0, wv1, wcp, ma, mb, mc, orig, res;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic            trk;

  assign pend    = job_i.slots & ~done_q;
  assign load_ok = !out_valid_q || out_ready_i;

  always_comb begin
    if (pend[0])      sel = SlotUpPrev;
    else if (pend[1]) sel = SlotUpLast;
    else if (pend[2]) sel = SlotBotPrev;
    else              sel = SlotBotLast;
  end

  assign sel_mask  = SlotN'(1) << sel;
  assign last_slot = ((pend & ~sel_mask) == '0);
  assign emit      = job_valid_i && (pend != '0) && load_ok;
  assign pop_o     = job_valid_i && ((pend == '0) || (load_ok && last_slot));

  // Operand selection for the chosen slot
  always_comb begin
    trk = sel[1];
    vc  = trk ? job_i.vc1 : job_i.vc0;
    pc  = trk ? job_i.pc1 : job_i.pc0;
    wv0 = win_v0_q[trk];
    wv1 = win_v1_q[trk];
    wcp = win_cp_q[trk];
    row = trk ? job_i.row : job_i.row - RowW'(1);
    if (!sel[0]) begin
      // mirror the left neighbor at the first column
      ma   = (job_i.col > ColW'(1)) ? wv0 : vc;
      mb   = wv1;
      mc   = vc;
      orig = wcp;
      col  = job_i.col - ColW'(1);
    end else begin
      ma   = wv1;
      mb   = vc;
      mc   = wv1;
      orig = pc;
      col  = job_i.col;
    end
    res = choose(mean3(ma, mb, mc), orig, thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < 2; t++) begin
        win_v0_q[t] <= '0;
        win_v1_q[t] <= '0;
        win_cp_q[t] <= '0;
      end
    end else begin
      if (load_ok) out_valid_q <= emit;
      if (pop_o) begin
        done_q <= '0;
        // advance both tracks below row 0; the last-row track is read only on
        // the last row, whose own pixels refill it before each read
        if (job_i.row != '0) begin
          win_v0_q[0] <= win_v1_q[0];
          win_v1_q[0] <= job_i.vc0;
          win_cp_q[0] <= job_i.pc0;
          win_v0_q[1] <= win_v1_q[1];
          win_v1_q[1] <= job_i.vc1;
          win_cp_q[1] <= job_i.pc1;
        end
      end else if (emit) begin
        done_q <= done_q | sel_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pix_q  <= res;
      out_col_q  <= col;
      out_row_q  <= row;
      out_last_q <= (sel == SlotBotLast);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_last_o  = out_last_q;

endmodule

@@ design/threshold_selective_box_smoothing.sv @@
// Top level of the threshold-selective 3x3 box smoother for RGB streams.
// Usage:
//   Pixels enter in raster order on the s_axis group, one transfer per pixel.
//   Smoothed-or-original pixels leave on the m_axis group with their column
//   and row; tlast marks the final pixel of a frame. Output (x,y) leaves once
//   input (x+1,y+1) is in; the last column and last row leave early.
//   Width, height and threshold are written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i; width and height are latched at the first pixel of a frame.
// Path: a result completed by an input transfer passes the input stage with line store
//   read, a queue entry and the result register before it is valid on m_axis; further
//   results of the same pixel follow one by one.
// Throughput: the front takes one pixel per cycle while the queue accepts; the back forms
//   one result per cycle while the output is not stalled. Past the first column a pixel
//   completes one result in inner rows, two at a row end, two on the last row and four on
//   the final pixel. The four-entry job queue absorbs these bursts.
// Reset: position counters, queue and output valid clear at once; the line
//   store needs no clearing, since each frame writes a row before reading it.
// Stall: while m_axis_tready is low the output register holds, the back
//   stops, the queue fills and then s_axis_tready drops.
module threshold_selective_box_smoothing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_red, out_green, out_blue, out_col, out_row, pad
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);
  import tsbs_pkg::*;

  logic [DimW-1:0] cfg_width_q, cfg_height_q;
  logic [ThrW-1:0] cfg_thr_q;

  logic            push, q_full, q_valid, pop;
  job_t            job_in, job_out;
  pix_t            out_pix;
  logic [ColW-1:0] out_col;
  logic [RowW-1:0] out_row;

  // Hold the configuration registers; writes must arrive only while idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      cfg_thr_q    <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  cfg_width_q  <= cfg_wdata_i[DimW-1:0];
        CfgHeight: cfg_height_q <= cfg_wdata_i[DimW-1:0];
        CfgThresh: cfg_thr_q    <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Front: track position, read the two stored rows, form vertical means
  tsbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pix_i     (s_axis_tdata),
    .cfg_width_i  (cfg_width_q),
    .cfg_height_i (cfg_height_q),
    .push_o       (push),
    .job_o        (job_in),
    .q_full_i     (q_full)
  );

  // Queue: decouple the front, one pixel per cycle while not full, from the bursty back
  tsbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  // Back: horizontal means, threshold select, one result per cycle while the output is not stalled
  tsbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .thr_i       (cfg_thr_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_row[9:0], out_col[9:0], out_pix};

endmodule

@@ test/testbench.sv @@
// Self-checking stream testbench for the threshold-selective box smoother.
`timescale 1ns / 100ps

module testbench;
  import tsbs_pkg::*;

  // One result pixel as it leaves the master side
  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             fe;
  } out_px_t;

  // Pixel content styles for a frame
  typedef enum int {
    StyleNoise,
    StyleExtreme,
    StyleFlat,
    StyleChecker
  } px_style_e;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_we_i      = 1'b0;
  logic [1:0]       cfg_idx_i     = CfgWidth;
  logic [DimW-1:0]  cfg_wdata_i   = '0;

  threshold_selective_box_smoothing i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // ---------------------------------------------------------------------------
  pix_t        raster_q[$];      // pixels waiting for the driver, raster order
  out_px_t     smoothed_q[$];    // predicted output pixels, oldest first
  int unsigned pixels_fed    = 0;
  int unsigned pixels_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned phase_count   = 0;
  int unsigned errors        = 0;
  bit          quiet         = 1'b0;  // no idling on either side when set
  string       field_name[6] = '{"red", "green", "blue", "col", "row", "frame_end"};

  // ---------------------------------------------------------------------------
  // Smoothing predictor: own copy of the line stores, windows and registers
  // ---------------------------------------------------------------------------
  pix_t            prev2_row[MaxWidth];   // row r-2
  pix_t            prev1_row[MaxWidth];   // row r-1
  // per output track t: [2t] vertical mean at column c-2, [2t+1] at c-1
  pix_t            vmean_win[4]  = '{default: '0};
  // per output track t: centre pixel at column c-1
  pix_t            centre_win[2] = '{default: '0};
  int unsigned     in_col  = 0;
  int unsigned     in_row  = 0;
  int unsigned     frame_w = 512;
  int unsigned     frame_h = 512;
  logic [DimW-1:0] cfg_w   = WidthReset;
  logic [DimW-1:0] cfg_h   = HeightReset;
  logic [ThrW-1:0] cfg_thr = ThreshReset;

  function automatic int unsigned dim_clamp(logic [DimW-1:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Per channel floor((a+b+c)/3)
  function automatic pix_t avg3(pix_t a, pix_t b, pix_t c);
    pix_t        r;
    int unsigned s;
    for (int k = 0; k < 3; k++) begin
      s = int'(a[k*ChanW +: ChanW]) + int'(b[k*ChanW +: ChanW]) + int'(c[k*ChanW +: ChanW]);
      r[k*ChanW +: ChanW] = ChanW'(s / 3);
    end
    return r;
  endfunction

  // Take the smoothed channel only where it strays past the threshold
  function automatic pix_t select_px(pix_t sm, pix_t orig);
    pix_t r;
    int   s;
    int   o;
    int   d;
    for (int k = 0; k < 3; k++) begin
      s = int'(sm[k*ChanW +: ChanW]);
      o = int'(orig[k*ChanW +: ChanW]);
      d = (s > o) ? s - o : o - s;
      r[k*ChanW +: ChanW] = (d > int'(cfg_thr)) ? sm[k*ChanW +: ChanW] : orig[k*ChanW +: ChanW];
    end
    return r;
  endfunction

  function automatic void push_out(pix_t p, int unsigned col, int unsigned row, logic fe);
    out_px_t o;
    o.red   = p[0 +: ChanW];
    o.green = p[ChanW +: ChanW];
    o.blue  = p[2*ChanW +: ChanW];
    o.col   = ColW'(col);
    o.row   = RowW'(row);
    o.fe    = fe;
    smoothed_q.push_back(o);
  endfunction

  // Advance one output track by a new vertical mean vc with centre pixel pc
  function automatic void window_step(int t, int unsigned rr, int unsigned c, pix_t vc,
                                      pix_t pc);
    pix_t left;
    if (c >= 1) begin
      // left edge mirrors: column -1 is replaced by column 1
      left = (c >= 2) ? vmean_win[2*t] : vc;
      push_out(select_px(avg3(left, vmean_win[2*t+1], vc), centre_win[t]), c - 1, rr, 1'b0);
    end
    if (c == frame_w - 1) begin
      // right edge mirrors: column W is replaced by column W-2
      push_out(select_px(avg3(vmean_win[2*t+1], vc, vmean_win[2*t+1]), pc), c, rr,
               rr == frame_h - 1);
    end
    vmean_win[2*t]   = vmean_win[2*t+1];
    vmean_win[2*t+1] = vc;
    centre_win[t]    = pc;
  endfunction

  // Fold one accepted input pixel into the predictor
  function automatic void smooth_predict(pix_t p);
    int unsigned c;
    int unsigned r;
    pix_t        mid;
    pix_t        above;
    // size is latched at the first pixel of a frame only
    if (in_col == 0 && in_row == 0) begin
      frame_w = dim_clamp(cfg_w, MaxWidth);
      frame_h = dim_clamp(cfg_h, MaxHeight);
    end
    c = in_col;
    r = in_row;
    if (r >= 1) begin
      mid   = prev1_row[c];
      // top edge mirrors: row -1 is replaced by row 1
      above = (r >= 2) ? prev2_row[c] : p;
      window_step(0, r - 1, c, avg3(above, mid, p), mid);
      // last row is emitted while it arrives, bottom edge mirrored
      if (r == frame_h - 1) window_step(1, r, c, avg3(mid, p, mid), p);
    end
    prev2_row[c] = prev1_row[c];
    prev1_row[c] = p;
    in_col = c + 1;
    if (in_col >= frame_w) begin
      in_col = 0;
      in_row = r + 1;
      if (in_row >= frame_h) in_row = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed raster_q onto the slave side with random idle bursts
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        smooth_predict(s_axis_tdata);
        pixels_sent++;
      end
      // hold the current pixel until its transfer completes
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (raster_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= raster_q.pop_front();
          if (!quiet && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the master side in bursts and check every transfer
  // ---------------------------------------------------------------------------
  int unsigned recv_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_px_t want;
    int      want_v[6];
    int      got_v[6];
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (smoothed_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, actual tdata=%h last=%b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want   = smoothed_q.pop_front();
          want_v = '{int'(want.red), int'(want.green), int'(want.blue),
                     int'(want.col), int'(want.row), int'(want.fe)};
          got_v  = '{int'(m_axis_tdata[7:0]), int'(m_axis_tdata[15:8]),
                     int'(m_axis_tdata[23:16]), int'(m_axis_tdata[33:24]),
                     int'(m_axis_tdata[43:34]), int'(m_axis_tlast)};
          for (int k = 0; k < 6; k++) begin
            if (want_v[k] != got_v[k]) begin
              errors++;
              $display("%0t: %s mismatch at pixel (%0d,%0d): expected %0d, actual %0d",
                       $time, field_name[k], want.col, want.row, want_v[k], got_v[k]);
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 17);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait until every fed pixel is in and every predicted result is out, then
  // let the pipeline settle, since row-0 pixels complete no result.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixels_sent != pixels_fed || smoothed_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write; call at a rising edge, returns once the write is clocked in
  task automatic cfg_write(logic [1:0] idx, logic [DimW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgWidth:  cfg_w   = val;
      CfgHeight: cfg_h   = val;
      CfgThresh: cfg_thr = val[ThrW-1:0];
      default: ;
    endcase
  endtask

  // Drain, then program all three registers
  task automatic set_dims(logic [DimW-1:0] w, logic [DimW-1:0] h, logic [ThrW-1:0] thr);
    wait_idle();
    cfg_write(CfgWidth, w);
    cfg_write(CfgHeight, h);
    cfg_write(CfgThresh, DimW'(thr));
    cfg_we_i <= 1'b0;
    phase_count++;
  endtask

  task automatic feed_pixels(int unsigned n, px_style_e style);
    pix_t px;
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        StyleExtreme: begin
          for (int k = 0; k < 3; k++) px[k*ChanW +: ChanW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        StyleFlat: begin
          // narrow spread so the threshold decision goes both ways
          for (int k = 0; k < 3; k++) px[k*ChanW +: ChanW] = ChanW'(100 + $urandom_range(0, 60));
        end
        StyleChecker: px = (i % 2 == 0) ? 24'hFFFFFF : 24'h000000;
        default: px = PixW'($urandom());
      endcase
      raster_q.push_back(px);
    end
    pixels_fed += n;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [DimW-1:0] wreg;
    logic [DimW-1:0] hreg;
    logic [ThrW-1:0] thr;
    int unsigned     n;
    int unsigned     rand_pixels;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest frame at the reset threshold with rail values,
    // sizes below the minimum clamped up, threshold at both extremes.
    set_dims(DimW'(2), DimW'(2), ThreshReset);
    feed_pixels(4, StyleExtreme);
    set_dims(DimW'(0), DimW'(1), ThrW'(0));
    feed_pixels(4, StyleFlat);
    set_dims(DimW'(3), DimW'(3), ThrW'(255));
    feed_pixels(9, StyleExtreme);
    set_dims(DimW'(3), DimW'(2), ThrW'(0));
    feed_pixels(6, StyleChecker);

    // Size written mid-frame must wait for the next frame: start a 5x3 frame,
    // drain, rewrite width and height, finish it, then run a 3x2 frame.
    set_dims(DimW'(5), DimW'(3), ThrW'(20));
    feed_pixels(7, StyleNoise);
    wait_idle();
    cfg_write(CfgWidth, DimW'(3));
    cfg_write(CfgHeight, DimW'(2));
    cfg_we_i <= 1'b0;
    feed_pixels(8, StyleFlat);
    feed_pixels(6, StyleNoise);

    // Random small frames, now and then with out-of-range size registers
    rand_pixels = 0;
    while (rand_pixels < 30) begin
      wreg = ($urandom_range(0, 7) == 0) ? DimW'($urandom_range(0, 1)) : DimW'($urandom_range(2, 9));
      hreg = ($urandom_range(0, 7) == 0) ? DimW'($urandom_range(0, 1)) : DimW'($urandom_range(2, 6));
      case ($urandom_range(0, 3))
        0:       thr = ThrW'(0);
        1:       thr = ThrW'(255);
        2:       thr = ThrW'($urandom_range(0, 40));
        default: thr = ThrW'($urandom_range(0, 255));
      endcase
      n = dim_clamp(wreg, MaxWidth) * dim_clamp(hreg, MaxHeight);
      set_dims(wreg, hreg, thr);
      feed_pixels(n, px_style_e'($urandom_range(0, 3)));
      rand_pixels += n;
    end

    // Closing frames at full rate on both sides
    quiet = 1'b1;
    set_dims(DimW'(4), DimW'(3), ThrW'($urandom_range(0, 255)));
    feed_pixels(12, StyleNoise);
    set_dims(DimW'(6), DimW'(4), ThrW'($urandom_range(0, 40)));
    feed_pixels(24, StyleFlat);

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (smoothed_q.size() != 0) begin
      errors++;
      $display("%0t: results still expected at the end: expected 0 left, actual %0d left",
               $time, smoothed_q.size());
    end

    $display("Covered %0d pixels over %0d register settings (small frames, clamped sizes,",
             pixels_sent, phase_count);
    $display("thresholds 0 to 255), with %0d results checked and %0d field mismatches.",
             results_seen, errors);
    if (errors == 0) begin
      $display("threshold_selective_box_smoothing verification clean");
    end else begin
      $display("threshold_selective_box_smoothing verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #50_000_000;
    $display("threshold_selective_box_smoothing verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/tsbs_pkg.sv
design/tsbs_front.sv
design/tsbs_queue.sv
design/tsbs_back.sv
design/threshold_selective_box_smoothing.sv
test/testbench.sv
